// ===== sv/cmm_pkg.sv =====
`timescale 1ns / 1ps
package cmm_pkg;

   localparam int MAX_DIM_C   = 8;
   localparam int FRAC_BITS_C = 14;

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   localparam logic [1:0] CSR_A_ROWS = 2'd0;
   localparam logic [1:0] CSR_INNER  = 2'd1;
   localparam logic [1:0] CSR_B_COLS = 2'd2;

   typedef struct packed {
      logic [1:0]   op;
      logic [2:0]   row;
      logic [2:0]   col;
      logic signed [15:0] re;
      logic signed [15:0] im;
   } req_type;

   typedef struct packed {
      logic [2:0]   out_row;
      logic [2:0]   out_col;
      logic signed [15:0] out_re;
      logic signed [15:0] out_im;
      logic         saturated;
      logic         last;
   } rsp_type;

   // A element travelling down the cell chain
   typedef struct packed {
      logic         valid;
      logic         first;
      logic [2:0]   k;
      logic signed [15:0] a_re;
      logic signed [15:0] a_im;
   } link_type;

   // B element write into the cells
   typedef struct packed {
      logic         en;
      logic [2:0]   row;
      logic [2:0]   col;
      logic [31:0]  data;
   } bwr_type;

   function automatic logic [3:0] clamp_dim(input logic [3:0] v, input int maxd);
      logic [3:0] r;
      r = v;
      if (v == 4'd0) r = 4'd1;
      else if (int'(v) > maxd) r = 4'(maxd);
      return r;
   endfunction

endpackage

// ===== sv/cmm_cell.sv =====
`timescale 1ns / 1ps
module cmm_cell #(
   parameter int MAX_DIM   = cmm_pkg::MAX_DIM_C,
   parameter int FRAC_BITS = cmm_pkg::FRAC_BITS_C,
   parameter int COL       = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  cmm_pkg::bwr_type   bwr,
   input  cmm_pkg::link_type  link_in,
   output cmm_pkg::link_type  link_out,
   output logic signed [15:0] res_re,
   output logic signed [15:0] res_im,
   output logic               res_sat
);
   import cmm_pkg::*;

   localparam int KW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ACC_W = 34 + $clog2(MAX_DIM);

   logic [31:0] b_col_ff [MAX_DIM];   // column COL of B, indexed by k

   link_type s1_ff;
   logic s2_valid_ff, s2_first_ff;
   logic signed [31:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;

   logic [31:0] b_word;
   logic signed [15:0] b_re, b_im;
   logic signed [ACC_W-1:0] d_re, d_im;
   logic signed [ACC_W-1:0] rnd_re, rnd_im;
   logic sat_re, sat_im;

   always_ff @(posedge clock) begin
      if (bwr.en && int'(bwr.col) == COL) begin
         b_col_ff[bwr.row[KW-1:0]] <= bwr.data;
      end
   end

   assign b_word = b_col_ff[s1_ff.k[KW-1:0]];
   assign b_re   = b_word[31:16];
   assign b_im   = b_word[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_ff.valid <= link_in.valid;
         s2_valid_ff <= s1_ff.valid;
      end
      s1_ff.first <= link_in.first;
      s1_ff.k     <= link_in.k;
      s1_ff.a_re  <= link_in.a_re;
      s1_ff.a_im  <= link_in.a_im;
      s2_first_ff <= s1_ff.first;
      p_rr_ff <= s1_ff.a_re * b_re;
      p_ii_ff <= s1_ff.a_im * b_im;
      p_ri_ff <= s1_ff.a_re * b_im;
      p_ir_ff <= s1_ff.a_im * b_re;
   end

   assign link_out = s1_ff;

   assign d_re = ACC_W'(p_rr_ff) - ACC_W'(p_ii_ff);
   assign d_im = ACC_W'(p_ri_ff) + ACC_W'(p_ir_ff);

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_re_ff <= s2_first_ff ? d_re : acc_re_ff + d_re;
         acc_im_ff <= s2_first_ff ? d_im : acc_im_ff + d_im;
      end
   end

   // round half up, then clamp to 16 bits
   assign rnd_re = (acc_re_ff + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   assign rnd_im = (acc_im_ff + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

   always_comb begin
      sat_re = 1'b1;
      sat_im = 1'b1;
      if (rnd_re > ACC_W'(32767))       res_re = 16'sh7fff;
      else if (rnd_re < -ACC_W'(32768)) res_re = 16'sh8000;
      else begin
         res_re = rnd_re[15:0];
         sat_re = 1'b0;
      end
      if (rnd_im > ACC_W'(32767))       res_im = 16'sh7fff;
      else if (rnd_im < -ACC_W'(32768)) res_im = 16'sh8000;
      else begin
         res_im = rnd_im[15:0];
         sat_im = 1'b0;
      end
   end

   assign res_sat = sat_re | sat_im;

endmodule

// ===== sv/complex_matrix_multiply.sv =====
`timescale 1ns / 1ps
// Loads (A or B word): busy stays low, so the next word is accepted next cycle.
// Compute: per row of C, A words enter the MAC cell chain one per cycle, drain
//   through all cells, then one result word per cycle; the receiver cannot stall.
// Sync active-high reset: sizes go to MAX_DIM, control idles; stores are not cleared.
module complex_matrix_multiply #(
   parameter int MAX_DIM   = cmm_pkg::MAX_DIM_C,
   parameter int FRAC_BITS = cmm_pkg::FRAC_BITS_C
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cmm_pkg::req_type req_data,
   output logic             rsp_valid,
   output cmm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [3:0]       csr_wdata
);
   import cmm_pkg::*;

   localparam int KW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int AW        = $clog2(DEPTH);
   localparam int DRAIN_LEN = MAX_DIM + 3;       // last A word to last accumulator
   localparam int DW        = $clog2(DRAIN_LEN);

   typedef enum logic [1:0] {IDLE, FEED, DRAIN, EMIT} state_type;

   state_type state_ff;
   logic [3:0] a_rows_ff, inner_ff, b_cols_ff;
   logic [2:0] row_ff, k_ff, col_ff;
   logic [DW-1:0] cnt_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic [31:0] a_mem [DEPTH];
   link_type head_ff;                 // registered A read, enters cell 0

   link_type link [MAX_DIM+1];
   logic signed [15:0] res_re [MAX_DIM];
   logic signed [15:0] res_im [MAX_DIM];
   logic res_sat [MAX_DIM];

   logic accept, load_a, load_b, go;
   logic [AW-1:0] wr_addr, rd_addr;
   bwr_type bwr;

   assign accept = start && !busy;
   assign load_a = accept && req_data.op == OP_LOAD_A
                   && {1'b0, req_data.row} < a_rows_ff && {1'b0, req_data.col} < inner_ff;
   assign load_b = accept && req_data.op == OP_LOAD_B
                   && {1'b0, req_data.row} < inner_ff && {1'b0, req_data.col} < b_cols_ff;
   assign go     = accept && req_data.op == OP_COMPUTE;

   assign wr_addr = AW'(AW'(req_data.row[KW-1:0]) * MAX_DIM) + AW'(req_data.col[KW-1:0]);
   assign rd_addr = AW'(AW'(row_ff[KW-1:0]) * MAX_DIM) + AW'(k_ff[KW-1:0]);

   assign bwr.en   = load_b;
   assign bwr.row  = req_data.row;
   assign bwr.col  = req_data.col;
   assign bwr.data = {req_data.re, req_data.im};

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= clamp_dim(4'd8, MAX_DIM);
         inner_ff  <= clamp_dim(4'd8, MAX_DIM);
         b_cols_ff <= clamp_dim(4'd8, MAX_DIM);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_A_ROWS: a_rows_ff <= clamp_dim(csr_wdata, MAX_DIM);
            CSR_INNER:  inner_ff  <= clamp_dim(csr_wdata, MAX_DIM);
            CSR_B_COLS: b_cols_ff <= clamp_dim(csr_wdata, MAX_DIM);
            default: ;
         endcase
      end
   end

   // A store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (load_a) a_mem[wr_addr] <= {req_data.re, req_data.im};
      head_ff.a_re  <= a_mem[rd_addr][31:16];
      head_ff.a_im  <= a_mem[rd_addr][15:0];
      head_ff.k     <= k_ff;
      head_ff.first <= (k_ff == 3'd0);
      if (reset) head_ff.valid <= 1'b0;
      else       head_ff.valid <= (state_ff == FEED);
   end

   // cell chain: A words ripple from cell to cell, each cell owns a column of B
   assign link[0] = head_ff;
   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      cmm_cell #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .COL(j)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .bwr     (bwr),
         .link_in (link[j]),
         .link_out(link[j+1]),
         .res_re  (res_re[j]),
         .res_im  (res_im[j]),
         .res_sat (res_sat[j])
      );
   end

   // sequencer and result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         row_ff <= '0;
         k_ff   <= '0;
         col_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (go) begin
                  state_ff <= FEED;
                  row_ff   <= '0;
                  k_ff     <= '0;
               end
            end
            FEED: begin
               k_ff <= k_ff + 3'd1;
               if ({1'b0, k_ff} == inner_ff - 4'd1) begin
                  state_ff <= DRAIN;
                  cnt_ff   <= '0;
               end
            end
            DRAIN: begin
               cnt_ff <= cnt_ff + DW'(1);
               if (cnt_ff == DW'(DRAIN_LEN - 1)) begin
                  state_ff <= EMIT;
                  col_ff   <= '0;
               end
            end
            EMIT: begin
               rsp_valid_ff      <= 1'b1;
               rsp_ff.out_row    <= row_ff;
               rsp_ff.out_col    <= col_ff;
               rsp_ff.out_re     <= res_re[col_ff[KW-1:0]];
               rsp_ff.out_im     <= res_im[col_ff[KW-1:0]];
               rsp_ff.saturated  <= res_sat[col_ff[KW-1:0]];
               rsp_ff.last       <= ({1'b0, row_ff} == a_rows_ff - 4'd1)
                                    && ({1'b0, col_ff} == b_cols_ff - 4'd1);
               col_ff <= col_ff + 3'd1;
               if ({1'b0, col_ff} == b_cols_ff - 4'd1) begin
                  if ({1'b0, row_ff} == a_rows_ff - 4'd1) begin
                     state_ff <= IDLE;
                  end else begin
                     state_ff <= FEED;
                     row_ff   <= row_ff + 3'd1;
                     k_ff     <= '0;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result word after last");

   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      go |=> busy)
      else $error("compute accepted but not busy");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result word while idle");

   a_rsp_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.out_row} < a_rows_ff
                     && {1'b0, rsp_data.out_col} < b_cols_ff))
      else $error("result word outside configured size");

endmodule
